FILE: rtl/rlcf_pkg.sv
// Shared types and constants for the RGB level crossfader.
package rlcf_pkg;

	localparam int FRACTION_BITS_DEF = 8;
	localparam int DENSITY_BITS_DEF  = 16;

	localparam int TICK_W      = 15;
	localparam int COLOUR_W    = 8;
	localparam int DENS_IN_W   = 16;
	localparam int DENS_OUT_W  = 24;
	localparam int GRAY_LEVEL  = 77;
	localparam int COLOUR_MAX  = 255;

	localparam logic MODE_TICK     = 1'b0;
	localparam logic MODE_RETARGET = 1'b1;

	typedef struct packed {
		logic                 mode;
		logic [DENS_IN_W-1:0] new_density;
		logic [COLOUR_W-1:0]  new_red;
		logic [COLOUR_W-1:0]  new_green;
		logic [COLOUR_W-1:0]  new_blue;
		logic [TICK_W-1:0]    fade_ticks;
	} rlcf_item_t;

	typedef struct packed {
		logic [DENS_OUT_W-1:0] density_now;
		logic [COLOUR_W-1:0]   red_now;
		logic [COLOUR_W-1:0]   green_now;
		logic [COLOUR_W-1:0]   blue_now;
		logic                  fog_on;
		logic                  fading;
	} rlcf_blend_t;

	// Lane control: start with latched operands, release a finished result.
	typedef struct packed {
		logic go;
		logic ack;
	} rlcf_lane_cmd_t;

endpackage

FILE: rtl/rlcf_lane.sv
// One blend lane: two products, a rounding add and a restoring divider.
module rlcf_lane #(
	parameter int VW = 16,
	parameter int LW = 15
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rlcf_pkg::rlcf_lane_cmd_t cmd,
	input  logic [VW-1:0]           start_fx,
	input  logic [VW-1:0]           tgt_fx,
	input  logic [LW-1:0]           len,
	input  logic [LW-1:0]           rem,
	output logic                    done,
	output logic [VW-1:0]           result
);
	import rlcf_pkg::*;

	localparam int PW = VW + LW;
	localparam int NW = VW + LW + 1;
	localparam int CW = $clog2(VW);

	typedef enum logic [4:0] {
		L_IDLE = 5'b00001,
		L_MUL  = 5'b00010,
		L_ADD  = 5'b00100,
		L_DIV  = 5'b01000,
		L_DONE = 5'b10000
	} lane_state_t;

	lane_state_t     state_q;
	logic [VW-1:0]   start_q;
	logic [VW-1:0]   tgt_q;
	logic [LW-1:0]   len_q;
	logic [LW-1:0]   rem_q;
	logic [PW-1:0]   prod_a_q;
	logic [PW-1:0]   prod_b_q;
	logic [LW-1:0]   prem_q;
	logic [VW-1:0]   quo_q;
	logic [CW-1:0]   cnt_q;

	logic            bypass;
	logic [NW-1:0]   num;
	logic [LW:0]     trial;
	logic [LW:0]     diff;
	logic            ge;

	assign bypass = (rem == '0) || (len == '0) || (rem > len);
	assign num    = NW'(prod_a_q) + NW'(prod_b_q) + NW'(len_q >> 1);
	assign trial  = {prem_q, quo_q[VW-1]};
	assign ge     = trial >= {1'b0, len_q};
	assign diff   = trial - {1'b0, len_q};

	assign done   = (state_q == L_DONE);
	assign result = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (cmd.go) begin
						state_q <= bypass ? L_DONE : L_MUL;
					end
				end
				L_MUL:  state_q <= L_ADD;
				L_ADD:  state_q <= L_DIV;
				L_DIV: begin
					if (cnt_q == CW'(VW - 1)) begin
						state_q <= L_DONE;
					end
				end
				L_DONE: begin
					if (cmd.ack) begin
						state_q <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			L_IDLE: begin
				start_q <= start_fx;
				tgt_q   <= tgt_fx;
				len_q   <= len;
				rem_q   <= rem;
				quo_q   <= tgt_fx;
			end
			L_MUL: begin
				prod_a_q <= PW'(start_q) * PW'(rem_q);
				prod_b_q <= PW'(tgt_q) * PW'(len_q - rem_q);
			end
			L_ADD: begin
				// Upper part is below the divisor, so it seeds the remainder.
				prem_q <= num[VW +: LW];
				quo_q  <= num[VW-1:0];
				cnt_q  <= '0;
			end
			L_DIV: begin
				prem_q <= ge ? diff[LW-1:0] : trial[LW-1:0];
				quo_q  <= {quo_q[VW-2:0], ge};
				cnt_q  <= cnt_q + 1'b1;
			end
			L_DONE: begin
				quo_q <= quo_q;
			end
			default: begin
				quo_q <= quo_q;
			end
		endcase
	end

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == L_DIV |-> prem_q < len_q)
		else $error("partial remainder not below fade length");

	a_go_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> state_q == L_IDLE)
		else $error("lane started while busy");

endmodule

FILE: rtl/rlcf_merge.sv
// Merge stage: saturate density, round and clamp colours, hold the result word.
module rlcf_merge #(
	parameter int FRACTION_BITS = rlcf_pkg::FRACTION_BITS_DEF,
	parameter int DENSITY_BITS  = rlcf_pkg::DENSITY_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  logic [DENSITY_BITS+FRACTION_BITS-1:0] dens_fx,
	input  logic [rlcf_pkg::COLOUR_W+FRACTION_BITS-1:0] red_fx,
	input  logic [rlcf_pkg::COLOUR_W+FRACTION_BITS-1:0] green_fx,
	input  logic [rlcf_pkg::COLOUR_W+FRACTION_BITS-1:0] blue_fx,
	input  logic                                  fading,
	output logic                                  ready,
	output logic                                  blend_valid,
	input  logic                                  blend_stall,
	output rlcf_pkg::rlcf_blend_t                 blend_data
);
	import rlcf_pkg::*;

	localparam int VWD = DENSITY_BITS + FRACTION_BITS;
	localparam int VWC = COLOUR_W + FRACTION_BITS;
	localparam int EW  = (VWD > DENS_OUT_W) ? VWD : DENS_OUT_W;
	localparam int RW  = VWC + 1 - FRACTION_BITS;

	logic          valid_q;
	rlcf_blend_t   data_q;
	rlcf_blend_t   word;
	logic [EW-1:0] dens_ext;

	function automatic logic [COLOUR_W-1:0] colour_round(input logic [VWC-1:0] fx);
		logic [VWC:0]  sum;
		logic [RW-1:0] whole;
		sum   = {1'b0, fx} + (VWC+1)'(1 << (FRACTION_BITS - 1));
		whole = sum[VWC:FRACTION_BITS];
		if (whole > RW'(COLOUR_MAX)) begin
			return COLOUR_W'(COLOUR_MAX);
		end
		return whole[COLOUR_W-1:0];
	endfunction

	assign dens_ext = EW'(dens_fx);

	always_comb begin
		word = '0;
		if (dens_ext > EW'({DENS_OUT_W{1'b1}})) begin
			word.density_now = {DENS_OUT_W{1'b1}};
		end else begin
			word.density_now = dens_ext[DENS_OUT_W-1:0];
		end
		word.red_now   = colour_round(red_fx);
		word.green_now = colour_round(green_fx);
		word.blue_now  = colour_round(blue_fx);
		word.fog_on    = (word.density_now != '0);
		word.fading    = fading;
	end

	assign ready       = !valid_q || !blend_stall;
	assign blend_valid = valid_q;
	assign blend_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!blend_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= word;
		end
	end

endmodule

FILE: rtl/retargetable_rgb_level_crossfader_unit.sv
// Top level of the RGB level crossfader: fade state, lane control and merge.
// Flow: an accepted item runs the lane states L_MUL, L_ADD, L_DIV and L_DONE,
//   then is loaded into the merge output register once it is free; the density
//   lane's restoring divider (one quotient bit per cycle) is the longest step;
//   without a running fade the lanes skip straight to L_DONE.
// Items: one at a time; a new item is taken only after the last word has gone to the merge stage.
// Reset: asynchronous, clears fade state to gray 77 colour, zero density, no fade.
module retargetable_rgb_level_crossfader_unit #(
	parameter int FRACTION_BITS = rlcf_pkg::FRACTION_BITS_DEF,
	parameter int DENSITY_BITS  = rlcf_pkg::DENSITY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  rlcf_pkg::rlcf_item_t item_data,
	output logic                 blend_valid,
	input  logic                 blend_stall,
	output rlcf_pkg::rlcf_blend_t blend_data
);
	import rlcf_pkg::*;

	localparam int VWD = DENSITY_BITS + FRACTION_BITS;
	localparam int VWC = COLOUR_W + FRACTION_BITS;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CALC = 2'b10
	} top_state_t;

	top_state_t st_q;

	// Fade state.
	logic [DENSITY_BITS-1:0] tgt_dens_q;
	logic [COLOUR_W-1:0]     tgt_red_q, tgt_green_q, tgt_blue_q;
	logic [VWD-1:0]          start_dens_q;
	logic [VWC-1:0]          start_red_q, start_green_q, start_blue_q;
	logic [TICK_W-1:0]       len_q;
	logic [TICK_W-1:0]       rem_q;

	// Retarget with a fade length, applied once the lanes have the current blend.
	logic                    pend_long_q;
	rlcf_item_t              pend_q;

	logic                    accept;
	logic                    is_tick;
	logic                    quick_switch;
	logic                    long_retarget;
	logic [DENSITY_BITS-1:0] new_dens;

	logic [TICK_W-1:0]       op_len, op_rem;
	logic [DENSITY_BITS-1:0] op_dens;
	logic [COLOUR_W-1:0]     op_red, op_green, op_blue;

	rlcf_lane_cmd_t          cmd;
	logic [3:0]              lane_done;
	logic [VWD-1:0]          res_dens;
	logic [VWC-1:0]          res_red, res_green, res_blue;
	logic                    merge_ready;
	logic                    finish;
	logic                    fading_next;

	assign item_stall    = (st_q != ST_IDLE);
	assign accept        = item_valid && !item_stall;
	assign is_tick       = (item_data.mode == MODE_TICK);
	assign quick_switch  = (item_data.mode == MODE_RETARGET) && (item_data.fade_ticks == '0);
	assign long_retarget = (item_data.mode == MODE_RETARGET) && (item_data.fade_ticks != '0);
	assign new_dens      = DENSITY_BITS'(item_data.new_density);

	// Operands seen by the lanes: ticks blend with the decremented count,
	// a quick switch blends straight to the new target, a long retarget
	// captures the blend of the fade that is running now.
	always_comb begin
		op_len   = len_q;
		op_rem   = rem_q;
		op_dens  = tgt_dens_q;
		op_red   = tgt_red_q;
		op_green = tgt_green_q;
		op_blue  = tgt_blue_q;
		if (is_tick) begin
			op_rem = (rem_q != '0) ? rem_q - 1'b1 : '0;
		end else if (quick_switch) begin
			op_len   = '0;
			op_rem   = '0;
			op_dens  = new_dens;
			op_red   = item_data.new_red;
			op_green = item_data.new_green;
			op_blue  = item_data.new_blue;
		end
	end

	assign cmd.go  = accept;
	assign cmd.ack = finish;

	rlcf_lane #(.VW(VWD), .LW(TICK_W)) u_lane_dens (
		.clk, .arst_n, .cmd,
		.start_fx (start_dens_q),
		.tgt_fx   (VWD'(op_dens) << FRACTION_BITS),
		.len      (op_len),
		.rem      (op_rem),
		.done     (lane_done[0]),
		.result   (res_dens)
	);

	rlcf_lane #(.VW(VWC), .LW(TICK_W)) u_lane_red (
		.clk, .arst_n, .cmd,
		.start_fx (start_red_q),
		.tgt_fx   (VWC'(op_red) << FRACTION_BITS),
		.len      (op_len),
		.rem      (op_rem),
		.done     (lane_done[1]),
		.result   (res_red)
	);

	rlcf_lane #(.VW(VWC), .LW(TICK_W)) u_lane_green (
		.clk, .arst_n, .cmd,
		.start_fx (start_green_q),
		.tgt_fx   (VWC'(op_green) << FRACTION_BITS),
		.len      (op_len),
		.rem      (op_rem),
		.done     (lane_done[2]),
		.result   (res_green)
	);

	rlcf_lane #(.VW(VWC), .LW(TICK_W)) u_lane_blue (
		.clk, .arst_n, .cmd,
		.start_fx (start_blue_q),
		.tgt_fx   (VWC'(op_blue) << FRACTION_BITS),
		.len      (op_len),
		.rem      (op_rem),
		.done     (lane_done[3]),
		.result   (res_blue)
	);

	// Hand the word to the merge stage once every lane is done and the
	// output register is free (or being drained this cycle).
	assign finish      = (st_q == ST_CALC) && (&lane_done) && merge_ready;
	assign fading_next = pend_long_q || (rem_q != '0);

	rlcf_merge #(.FRACTION_BITS(FRACTION_BITS), .DENSITY_BITS(DENSITY_BITS)) u_merge (
		.clk, .arst_n,
		.load        (finish),
		.dens_fx     (res_dens),
		.red_fx      (res_red),
		.green_fx    (res_green),
		.blue_fx     (res_blue),
		.fading      (fading_next),
		.ready       (merge_ready),
		.blend_valid (blend_valid),
		.blend_stall (blend_stall),
		.blend_data  (blend_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (finish) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_dens_q    <= '0;
			tgt_red_q     <= COLOUR_W'(GRAY_LEVEL);
			tgt_green_q   <= COLOUR_W'(GRAY_LEVEL);
			tgt_blue_q    <= COLOUR_W'(GRAY_LEVEL);
			start_dens_q  <= '0;
			start_red_q   <= VWC'(GRAY_LEVEL) << FRACTION_BITS;
			start_green_q <= VWC'(GRAY_LEVEL) << FRACTION_BITS;
			start_blue_q  <= VWC'(GRAY_LEVEL) << FRACTION_BITS;
			len_q         <= '0;
			rem_q         <= '0;
			pend_long_q   <= 1'b0;
		end else if (accept) begin
			// Ticks and quick switches take effect at once.
			pend_long_q <= long_retarget;
			if (is_tick) begin
				rem_q <= op_rem;
			end else if (quick_switch) begin
				tgt_dens_q  <= new_dens;
				tgt_red_q   <= item_data.new_red;
				tgt_green_q <= item_data.new_green;
				tgt_blue_q  <= item_data.new_blue;
				len_q       <= '0;
				rem_q       <= '0;
			end
		end else if (finish && pend_long_q) begin
			// Captured blend becomes the new start point.
			start_dens_q  <= res_dens;
			start_red_q   <= res_red;
			start_green_q <= res_green;
			start_blue_q  <= res_blue;
			tgt_dens_q    <= DENSITY_BITS'(pend_q.new_density);
			tgt_red_q     <= pend_q.new_red;
			tgt_green_q   <= pend_q.new_green;
			tgt_blue_q    <= pend_q.new_blue;
			len_q         <= pend_q.fade_ticks;
			rem_q         <= pend_q.fade_ticks;
			pend_long_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= item_data;
		end
	end

	a_rem_within_len: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= len_q)
		else $error("remaining fade exceeds fade length");

	a_finish_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> st_q == ST_IDLE && blend_valid)
		else $error("finished item did not reach the output register");

endmodule

FILE: verif/tb_retargetable_rgb_level_crossfader_unit.sv
// Self-checking testbench for the RGB level crossfader: directed fades, backlog, random fades.
module tb_retargetable_rgb_level_crossfader_unit;
	import rlcf_pkg::*;

	localparam int FRAC         = FRACTION_BITS_DEF;
	localparam int DENS         = DENSITY_BITS_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 450;
	localparam int SETTLE       = 40;	// idle wait after the drain before the verdict

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	rlcf_item_t  item_data;
	logic        blend_valid;
	logic        blend_stall;
	rlcf_blend_t blend_data;

	retargetable_rgb_level_crossfader_unit #(
		.FRACTION_BITS(FRAC),
		.DENSITY_BITS (DENS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_data  (item_data),
		.blend_valid(blend_valid),
		.blend_stall(blend_stall),
		.blend_data (blend_data)
	);

	// Free-running clock, period 10.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Fade state mirrored from the block: targets are integers, starts carry FRAC fraction bits.
	logic [DENS_IN_W-1:0]      tgt_density;
	logic [COLOUR_W-1:0]       tgt_red, tgt_green, tgt_blue;
	logic [DENS_OUT_W-1:0]     st_density;
	logic [COLOUR_W+FRAC-1:0]  st_red, st_green, st_blue;
	logic [TICK_W-1:0]         fade_len, fade_left;

	rlcf_blend_t pending_blends[$];
	int          miss_count;
	int          cycle_count;

	// Sender and receiver pacing knobs, driven by the test tasks.
	bit tx_calm;
	bit rx_calm;
	int hold_req;
	int hold_left;
	int rx_run;
	bit rx_on;

	// Blend one channel: remaining/length of the start plus the rest of the target,
	// rounded half up. Fall back to the target whenever no fade is running.
	function automatic longint unsigned fade_mix(input longint unsigned start_fx,
			input longint unsigned tgt_int);
		longint unsigned tgt_fx;
		longint unsigned num;
		longint unsigned len;
		longint unsigned left;
		tgt_fx = tgt_int << FRAC;
		len    = fade_len;
		left   = fade_left;
		if (left == 0 || len == 0 || left > len)
			return tgt_fx;
		num = start_fx * left + tgt_fx * (len - left);
		return (num + (len >> 1)) / len;
	endfunction

	// Round a fixed-point colour to the nearest level and clamp to full scale.
	function automatic logic [COLOUR_W-1:0] colour_round(input longint unsigned fx);
		longint unsigned v;
		v = (fx + (64'd1 << (FRAC - 1))) >> FRAC;
		return (v > COLOUR_MAX) ? COLOUR_W'(COLOUR_MAX) : v[COLOUR_W-1:0];
	endfunction

	// Apply one accepted word to the mirrored fade state and return the blend it yields.
	task automatic advance_fade(input rlcf_item_t w, output rlcf_blend_t res);
		longint unsigned d;
		longint unsigned nd, nr, ng, nb;
		longint unsigned dmask;
		dmask = (64'd1 << DENS) - 1;
		if (w.mode == MODE_TICK) begin
			if (fade_left != 0)
				fade_left = fade_left - 1'b1;
		end else begin
			// Capture the current blend as the new start, but only for a timed fade.
			if (w.fade_ticks != 0) begin
				nd = fade_mix(st_density, tgt_density);
				nr = fade_mix(st_red, tgt_red);
				ng = fade_mix(st_green, tgt_green);
				nb = fade_mix(st_blue, tgt_blue);
				st_density = nd[DENS_OUT_W-1:0];
				st_red     = nr[COLOUR_W+FRAC-1:0];
				st_green   = ng[COLOUR_W+FRAC-1:0];
				st_blue    = nb[COLOUR_W+FRAC-1:0];
			end
			tgt_density = DENS_IN_W'(w.new_density & dmask);
			tgt_red     = w.new_red;
			tgt_green   = w.new_green;
			tgt_blue    = w.new_blue;
			fade_len    = w.fade_ticks;
			fade_left   = w.fade_ticks;
		end
		d = fade_mix(st_density, tgt_density);
		if (d > 64'hFF_FFFF)
			d = 64'hFF_FFFF;
		res.density_now = d[DENS_OUT_W-1:0];
		res.red_now     = colour_round(fade_mix(st_red, tgt_red));
		res.green_now   = colour_round(fade_mix(st_green, tgt_green));
		res.blue_now    = colour_round(fade_mix(st_blue, tgt_blue));
		res.fog_on      = (d != 0);
		res.fading      = (fade_left != 0);
	endtask

	// Count a mismatch; report only the first few in detail.
	task automatic note_miss(input string what, input longint unsigned want,
			input longint unsigned got);
		if (miss_count < 10)
			$display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
		miss_count++;
	endtask

	// Check every accepted result word against the oldest prediction.
	always @(posedge clk) begin
		rlcf_blend_t want;
		if (arst_n && blend_valid === 1'b1 && blend_stall === 1'b0) begin
			if (pending_blends.size() == 0) begin
				note_miss("unexpected word", 0, blend_data);
			end else begin
				want = pending_blends.pop_front();
				if (blend_data.density_now !== want.density_now)
					note_miss("density_now", want.density_now, blend_data.density_now);
				if (blend_data.red_now !== want.red_now)
					note_miss("red_now", want.red_now, blend_data.red_now);
				if (blend_data.green_now !== want.green_now)
					note_miss("green_now", want.green_now, blend_data.green_now);
				if (blend_data.blue_now !== want.blue_now)
					note_miss("blue_now", want.blue_now, blend_data.blue_now);
				if (blend_data.fog_on !== want.fog_on)
					note_miss("fog_on", want.fog_on, blend_data.fog_on);
				if (blend_data.fading !== want.fading)
					note_miss("fading", want.fading, blend_data.fading);
			end
		end
	end

	// Receiver pacing: a requested long hold wins, calm stretches never stall,
	// otherwise alternate random runs of stall and flow (mostly short, a few long).
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			blend_stall <= 1'b1;
		end else if (rx_calm) begin
			blend_stall <= 1'b0;
		end else begin
			if (rx_run == 0) begin
				rx_on  = ($urandom_range(0, 99) < 35);
				rx_run = !rx_on ? $urandom_range(1, 12) :
					($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
			end
			rx_run--;
			blend_stall <= rx_on;
		end
	end

	// Watchdog: give up well past the slowest legal run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic rlcf_item_t make_word(input logic m, input int dens, input int r,
			input int g, input int b, input int ticks);
		rlcf_item_t w;
		w.mode        = m;
		w.new_density = DENS_IN_W'(dens);
		w.new_red     = COLOUR_W'(r);
		w.new_green   = COLOUR_W'(g);
		w.new_blue    = COLOUR_W'(b);
		w.fade_ticks  = TICK_W'(ticks);
		return w;
	endfunction

	// Fully random word; the unused fields of a tick still toggle.
	function automatic rlcf_item_t noise_word();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(rlcf_item_t)-1:0];
	endfunction

	function automatic rlcf_item_t tick_word();
		rlcf_item_t w;
		w      = noise_word();
		w.mode = MODE_TICK;
		return w;
	endfunction

	function automatic int pick_level();
		int r;
		r = $urandom_range(0, 99);
		return (r < 15) ? 0 : (r < 30) ? COLOUR_MAX : $urandom_range(0, COLOUR_MAX);
	endfunction

	function automatic int pick_density();
		int r;
		r = $urandom_range(0, 99);
		return (r < 10) ? 0 : (r < 20) ? 16'hFFFF : $urandom_range(0, 16'hFFFF);
	endfunction

	// Mostly short fades so ticks run them out; some instant switches and full-range lengths.
	function automatic int pick_fade_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return $urandom_range(1, 8);
		if (r < 70) return $urandom_range(9, 64);
		if (r < 82) return 0;
		return $urandom_range(0, (1 << TICK_W) - 1);
	endfunction

	// Offer one word, hold it until accepted, predict its result, then maybe idle.
	// Valid is left high when no gap follows, so the next offer does not toggle it.
	task automatic send_word(input rlcf_item_t w);
		rlcf_blend_t res;
		int gap;
		item_data  <= w;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall !== 1'b0);
		advance_fade(w, res);
		pending_blends.push_back(res);
		gap = 0;
		if (!tx_calm) begin
			case ($urandom_range(0, 9))
				0, 1, 2:    gap = $urandom_range(1, 3);
				3:          gap = $urandom_range(10, 40);
				default:    gap = 0;
			endcase
		end
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every predicted word has come back.
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_blends.size() != 0)
			@(posedge clk);
	endtask

	// Ticks straight out of reset: gray colour, no fog, no fade.
	task automatic test_reset_idle();
		send_word(make_word(MODE_TICK, 0, 0, 0, 0, 0));
		send_word(tick_word());
	endtask

	// Zero-length retargets switch at once; hit the field extremes.
	task automatic test_instant_switch();
		send_word(make_word(MODE_RETARGET, 16'hFFFF, COLOUR_MAX, 0, COLOUR_MAX, 0));
		send_word(make_word(MODE_RETARGET, 0, 0, COLOUR_MAX, 0, 0));
		send_word(make_word(MODE_TICK, 16'hFFFF, COLOUR_MAX, COLOUR_MAX, COLOUR_MAX, 0));
	endtask

	// Fade from idle, run it out and past the end, then retarget mid-fade.
	task automatic test_fade_walk();
		send_word(make_word(MODE_RETARGET, 16'hFFFF, COLOUR_MAX, COLOUR_MAX, 0, 4));
		repeat (5) send_word(make_word(MODE_TICK, 0, 0, 0, 0, 0));
		// Longest fade: red and green full to zero, blue zero to full, density down to zero.
		send_word(make_word(MODE_RETARGET, 0, 0, 0, COLOUR_MAX, (1 << TICK_W) - 1));
		repeat (2) send_word(tick_word());
		// Retarget while fading: the start point is the current blend.
		send_word(make_word(MODE_RETARGET, 16'h1234, 128, 1, 254, 3));
		repeat (4) send_word(tick_word());
		send_word(make_word(MODE_RETARGET, 16'h8000, 77, 200, 33, 1));
		send_word(tick_word());
	endtask

	// Hold the receiver for a long stretch while words keep coming, so the block
	// backs up and stalls its input; then pause until everything is back.
	task automatic test_output_backlog();
		tx_calm  = 1'b1;
		rx_calm  = 1'b1;
		hold_req = 400;
		send_word(make_word(MODE_RETARGET, pick_density(), pick_level(), pick_level(),
			pick_level(), 6));
		repeat (12) send_word(tick_word());
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		wait_drained();
		send_word(make_word(MODE_RETARGET, pick_density(), pick_level(), pick_level(),
			pick_level(), 2));
		repeat (3) send_word(tick_word());
	endtask

	// Random fades: mostly a retarget followed by ticks that often run it out,
	// mixed with bursts of raw noise. Every fourth stretch runs with no idling.
	task automatic test_random_fades(input int goal);
		int sent;
		int len;
		int ticks;
		sent = 0;
		while (sent < goal) begin
			tx_calm = ((sent / 60) % 4 == 3);
			rx_calm = tx_calm;
			if ($urandom_range(0, 99) < 80) begin
				len = pick_fade_len();
				send_word(make_word(MODE_RETARGET, pick_density(), pick_level(), pick_level(),
					pick_level(), len));
				ticks = (len <= 64) ? $urandom_range(0, len + 3) : $urandom_range(1, 12);
				repeat (ticks) send_word(tick_word());
				sent += 1 + ticks;
			end else begin
				ticks = $urandom_range(1, 4);
				repeat (ticks) send_word(noise_word());
				sent += ticks;
			end
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	initial begin
		// Mirror the block's reset state: gray colour, zero density, no fade.
		tgt_density = '0;
		tgt_red     = COLOUR_W'(GRAY_LEVEL);
		tgt_green   = COLOUR_W'(GRAY_LEVEL);
		tgt_blue    = COLOUR_W'(GRAY_LEVEL);
		st_density  = '0;
		st_red      = (COLOUR_W + FRAC)'(GRAY_LEVEL) << FRAC;
		st_green    = (COLOUR_W + FRAC)'(GRAY_LEVEL) << FRAC;
		st_blue     = (COLOUR_W + FRAC)'(GRAY_LEVEL) << FRAC;
		fade_len    = '0;
		fade_left   = '0;
		miss_count  = 0;
		cycle_count = 0;
		tx_calm     = 1'b0;
		rx_calm     = 1'b0;
		hold_req    = 0;
		hold_left   = 0;
		rx_run      = 0;
		rx_on       = 1'b0;
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item_data   = '0;
		blend_stall = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_idle();
		test_instant_switch();
		test_fade_walk();
		test_output_backlog();
		test_random_fades(RANDOM_ITEMS);

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (miss_count == 0 && pending_blends.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/rlcf_pkg.sv
rtl/rlcf_lane.sv
rtl/rlcf_merge.sv
rtl/retargetable_rgb_level_crossfader_unit.sv
verif/tb_retargetable_rgb_level_crossfader_unit.sv
